// ----- sv/lavm_pkg.sv -----
`timescale 1ns / 1ps
package lavm_pkg;

  localparam int IN_W  = 32;
  localparam int OUT_W = 18;
  localparam int THR_W = 17;
  localparam logic [THR_W-1:0] THR_RST = 17'd1;

  // prescale target: largest magnitude in [2^PRE_MSB, 2^(PRE_MSB+1))
  localparam int PRE_MSB = 29;
  localparam int MAG_W   = PRE_MSB + 1;
  localparam int ROOT_W  = MAG_W + 1;
  localparam int REM_W   = ROOT_W + 2;

endpackage

// ----- sv/lavm_norm.sv -----
`timescale 1ns / 1ps
module lavm_norm
  import lavm_pkg::*;
#(
  parameter int VW        = 33,
  parameter int FRAC_BITS = 16,
  parameter int PW        = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [VW-1:0]    vec_i [3],
  input  logic [PW-1:0]           pay_i,
  output logic                    valid_o,
  output logic signed [FRAC_BITS+1:0] unit_o [3],
  output logic [PW-1:0]           pay_o
);

  localparam int UW  = FRAC_BITS + 2;
  localparam int PBW = $clog2(VW);
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = FRAC_BITS + MAG_W + 1;
  localparam int RW  = ROOT_W + 1;
  localparam int SQ  = ROOT_W;
  localparam int DQ  = QW;
  localparam int SW1 = 3 * MAG_W + 4 + PW;
  localparam int SW2 = 4 + PW;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  // stage 1: magnitudes and largest
  logic [VW-1:0] mg [3];
  logic [VW-1:0] big;
  logic          s1_v_q;
  logic [VW-1:0] s1_m_q [3];
  logic [2:0]    s1_neg_q;
  logic [VW-1:0] s1_big_q;
  logic [PW-1:0] s1_pay_q;

  always_comb begin
    big = '0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = vec_i[i][VW-1] ? VW'(-vec_i[i]) : VW'(vec_i[i]);
      if (mg[i] > big) big = mg[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else s1_v_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    s1_m_q   <= mg;
    s1_big_q <= big;
    s1_pay_q <= pay_i;
    for (int i = 0; i < 3; i++) s1_neg_q[i] <= vec_i[i][VW-1];
  end

  // stage 2: leading one position
  logic [PBW-1:0] lead;
  logic           s2_v_q;
  logic [VW-1:0]  s2_m_q [3];
  logic [2:0]     s2_neg_q;
  logic           s2_nz_q;
  logic [PBW-1:0] s2_p_q;
  logic [PW-1:0]  s2_pay_q;

  always_comb begin
    lead = '0;
    for (int i = 0; i < VW; i++) if (s1_big_q[i]) lead = PBW'(i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    s2_m_q   <= s1_m_q;
    s2_neg_q <= s1_neg_q;
    s2_nz_q  <= |s1_big_q;
    s2_p_q   <= lead;
    s2_pay_q <= s1_pay_q;
  end

  // stage 3: prescale
  logic [VW-1:0]    shd [3];
  logic             s3_v_q;
  logic [MAG_W-1:0] s3_m_q [3];
  logic [2:0]       s3_neg_q;
  logic             s3_nz_q;
  logic [PW-1:0]    s3_pay_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s2_p_q >= PBW'(PRE_MSB)) shd[i] = s2_m_q[i] >> (s2_p_q - PBW'(PRE_MSB));
      else shd[i] = s2_m_q[i] << (PBW'(PRE_MSB) - s2_p_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) s3_m_q[i] <= shd[i][MAG_W-1:0];
    s3_neg_q <= s2_neg_q;
    s3_nz_q  <= s2_nz_q;
    s3_pay_q <= s2_pay_q;
  end

  // stage 4: squares
  logic               s4_v_q;
  logic [2*MAG_W-1:0] s4_sq_q [3];
  logic [MAG_W-1:0]   s4_m_q [3];
  logic [2:0]         s4_neg_q;
  logic               s4_nz_q;
  logic [PW-1:0]      s4_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) s4_sq_q[i] <= s3_m_q[i] * s3_m_q[i];
    s4_m_q   <= s3_m_q;
    s4_neg_q <= s3_neg_q;
    s4_nz_q  <= s3_nz_q;
    s4_pay_q <= s3_pay_q;
  end

  // stage 5 and square root, one result bit per stage
  logic                sq_v_q  [0:SQ];
  logic [2*SQ-1:0]     sq_n_q  [0:SQ];
  logic [ROOT_W-1:0]   sq_rt_q [0:SQ];
  logic [REM_W-1:0]    sq_rm_q [0:SQ];
  logic [SW1-1:0]      sq_sd_q [0:SQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q[0] <= 1'b0;
    else sq_v_q[0] <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    sq_n_q[0]  <= (2*SQ)'(s4_sq_q[0]) + (2*SQ)'(s4_sq_q[1]) + (2*SQ)'(s4_sq_q[2]);
    sq_rt_q[0] <= '0;
    sq_rm_q[0] <= '0;
    sq_sd_q[0] <= {s4_m_q[0], s4_m_q[1], s4_m_q[2], s4_neg_q, s4_nz_q, s4_pay_q};
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [REM_W+1:0] rx;
    logic [REM_W-1:0] tr;
    logic             ge;

    assign rx = {sq_rm_q[k], sq_n_q[k][2*SQ-1-2*k -: 2]};
    assign tr = REM_W'({sq_rt_q[k], 2'b01});
    assign ge = rx >= {2'b00, tr};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k+1] <= 1'b0;
      else sq_v_q[k+1] <= sq_v_q[k];
    end

    always_ff @(posedge clk_i) begin
      sq_n_q[k+1]  <= sq_n_q[k];
      sq_rt_q[k+1] <= {sq_rt_q[k][ROOT_W-2:0], ge};
      sq_rm_q[k+1] <= ge ? REM_W'(rx - {2'b00, tr}) : REM_W'(rx);
      sq_sd_q[k+1] <= sq_sd_q[k];
    end
  end

  // numerators, then restoring division, one quotient bit per stage
  logic [MAG_W-1:0]  nm_m [3];
  logic [2:0]        nm_neg;
  logic              nm_nz;
  logic [PW-1:0]     nm_pay;
  logic [NW-1:0]     nm_n [3];

  logic              dv_v_q   [0:DQ];
  logic [NW-1:0]     dv_n_q   [0:DQ][3];
  logic [RW-1:0]     dv_r_q   [0:DQ][3];
  logic [QW-1:0]     dv_q_q   [0:DQ][3];
  logic [ROOT_W-1:0] dv_len_q [0:DQ];
  logic [SW2-1:0]    dv_sd_q  [0:DQ];

  always_comb begin
    {nm_m[0], nm_m[1], nm_m[2], nm_neg, nm_nz, nm_pay} = sq_sd_q[SQ];
    for (int i = 0; i < 3; i++)
      nm_n[i] = (NW'(nm_m[i]) << FRAC_BITS) + NW'(sq_rt_q[SQ] >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else dv_v_q[0] <= sq_v_q[SQ];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dv_n_q[0][i] <= nm_n[i];
      dv_r_q[0][i] <= RW'(nm_n[i] >> QW);
      dv_q_q[0][i] <= '0;
    end
    dv_len_q[0] <= sq_rt_q[SQ];
    dv_sd_q[0]  <= {nm_neg, nm_nz, nm_pay};
  end

  for (genvar k = 0; k < DQ; k++) begin : g_div
    logic [RW:0] rt [3];
    logic [2:0]  ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rt[i] = {dv_r_q[k][i], dv_n_q[k][i][FRAC_BITS-k]};
        ge[i] = rt[i] >= (RW+1)'(dv_len_q[k]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k+1] <= 1'b0;
      else dv_v_q[k+1] <= dv_v_q[k];
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_n_q[k+1][i] <= dv_n_q[k][i];
        dv_r_q[k+1][i] <= ge[i] ? RW'(rt[i] - (RW+1)'(dv_len_q[k])) : RW'(rt[i]);
        dv_q_q[k+1][i] <= {dv_q_q[k][i][QW-2:0], ge[i]};
      end
      dv_len_q[k+1] <= dv_len_q[k];
      dv_sd_q[k+1]  <= dv_sd_q[k];
    end
  end

  // sign and clamp
  logic [2:0]    fn_neg;
  logic          fn_nz;
  logic [PW-1:0] fn_pay;
  logic [QW-1:0] fn_q [3];
  logic          out_v_q;
  logic signed [UW-1:0] out_u_q [3];
  logic [PW-1:0] out_pay_q;

  always_comb begin
    {fn_neg, fn_nz, fn_pay} = dv_sd_q[DQ];
    for (int i = 0; i < 3; i++)
      fn_q[i] = (dv_q_q[DQ][i] > ONE_Q) ? ONE_Q : dv_q_q[DQ][i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else out_v_q <= dv_v_q[DQ];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (!fn_nz) out_u_q[i] <= '0;
      else if (fn_neg[i]) out_u_q[i] <= -$signed(UW'(fn_q[i]));
      else out_u_q[i] <= $signed(UW'(fn_q[i]));
    end
    out_pay_q <= fn_pay;
  end

  assign valid_o = out_v_q;
  assign unit_o  = out_u_q;
  assign pay_o   = out_pay_q;

endmodule

// ----- sv/look_at_view_matrix.sv -----
`timescale 1ns / 1ps
// Look-at camera basis. One camera set (eye, target, up hint) is taken in every
// cycle while start_i is high; busy_o is always low. Results are marked by done_o
// for one cycle and must be taken then. Most of the pipeline lies in two
// normalisers, each with a 31-stage square root and a FRAC_BITS + 1 stage
// divider, so its depth grows with FRAC_BITS (16 at Q16.16). degenerate_threshold
// is written through cfg_valid_i/cfg_ready_o and may be changed only while no
// transaction is in flight.
module look_at_view_matrix
  import lavm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [IN_W-1:0]  eye_x_i,
  input  logic signed [IN_W-1:0]  eye_y_i,
  input  logic signed [IN_W-1:0]  eye_z_i,
  input  logic signed [IN_W-1:0]  target_x_i,
  input  logic signed [IN_W-1:0]  target_y_i,
  input  logic signed [IN_W-1:0]  target_z_i,
  input  logic signed [IN_W-1:0]  up_hint_x_i,
  input  logic signed [IN_W-1:0]  up_hint_y_i,
  input  logic signed [IN_W-1:0]  up_hint_z_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [THR_W-1:0]        cfg_data_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] right_x_o,
  output logic signed [OUT_W-1:0] right_y_o,
  output logic signed [OUT_W-1:0] right_z_o,
  output logic signed [OUT_W-1:0] upward_x_o,
  output logic signed [OUT_W-1:0] upward_y_o,
  output logic signed [OUT_W-1:0] upward_z_o,
  output logic signed [OUT_W-1:0] forward_x_o,
  output logic signed [OUT_W-1:0] forward_y_o,
  output logic signed [OUT_W-1:0] forward_z_o,
  output logic signed [IN_W-1:0]  shift_x_o,
  output logic signed [IN_W-1:0]  shift_y_o,
  output logic signed [IN_W-1:0]  shift_z_o
);

  localparam int UW  = FRAC_BITS + 2;
  localparam int DFW = IN_W + 1;
  localparam int HPW = IN_W + UW;
  localparam int HSW = HPW + 2;
  localparam int DW  = IN_W + 3;
  localparam int PDW = DW + UW;
  localparam int CW  = DW + 1;
  localparam int FPW = 2 * UW;
  localparam int XPW = FPW + 1;
  localparam int EPW = IN_W + UW;
  localparam int ESW = EPW + 2;
  localparam int NSW = ESW + 1;
  localparam int SQW = 2 * THR_W;
  localparam int P1W = 6 * IN_W;
  localparam int P2W = 3 * IN_W + 3 * UW;

  localparam logic signed [UW-1:0]  ONE    = UW'(1) << FRAC_BITS;
  localparam logic signed [XPW-1:0] ONE_X  = XPW'(1) << FRAC_BITS;
  localparam logic signed [HSW-1:0] HALF_H = HSW'(1) << (FRAC_BITS - 1);
  localparam logic signed [FPW-1:0] HALF_F = FPW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PDW-1:0] HALF_D = PDW'(1) << (FRAC_BITS - 1);
  localparam logic signed [XPW-1:0] HALF_X = XPW'(1) << (FRAC_BITS - 1);
  localparam logic signed [ESW-1:0] HALF_E = ESW'(1) << (FRAC_BITS - 1);
  localparam logic signed [NSW-1:0] S_MAX  = NSW'(32'h7FFF_FFFF);
  localparam logic signed [NSW-1:0] S_MIN  = -(NSW'(1) << (IN_W - 1));

  // configuration
  logic [THR_W-1:0] thr_q;
  logic [SQW-1:0]   thr_sq_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RST;
      thr_sq_q <= SQW'(1);
    end else begin
      if (cfg_valid_i) thr_q <= cfg_data_i;
      thr_sq_q <= thr_q * thr_q;
    end
  end

  // T0: capture, forward difference
  logic signed [IN_W-1:0] eye_in [3];
  logic signed [IN_W-1:0] tgt_in [3];
  logic signed [IN_W-1:0] hint_in [3];
  logic                   v0_q;
  logic signed [IN_W-1:0] e0_q [3];
  logic signed [IN_W-1:0] h0_q [3];
  logic signed [DFW-1:0]  d0_q [3];

  assign eye_in  = '{eye_x_i, eye_y_i, eye_z_i};
  assign tgt_in  = '{target_x_i, target_y_i, target_z_i};
  assign hint_in = '{up_hint_x_i, up_hint_y_i, up_hint_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else v0_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    e0_q <= eye_in;
    h0_q <= hint_in;
    for (int i = 0; i < 3; i++) d0_q[i] <= DFW'(tgt_in[i]) - DFW'(eye_in[i]);
  end

  // forward normaliser
  logic                 n1_v;
  logic signed [UW-1:0] n1_u [3];
  logic [P1W-1:0]       n1_pay;

  lavm_norm #(
    .VW       (DFW),
    .FRAC_BITS(FRAC_BITS),
    .PW       (P1W)
  ) u_norm_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v0_q),
    .vec_i  (d0_q),
    .pay_i  ({e0_q[0], e0_q[1], e0_q[2], h0_q[0], h0_q[1], h0_q[2]}),
    .valid_o(n1_v),
    .unit_o (n1_u),
    .pay_o  (n1_pay)
  );

  // T1: eye on target gives +Z
  logic                   v1_q;
  logic signed [UW-1:0]   f1_q [3];
  logic signed [IN_W-1:0] e1_q [3];
  logic signed [IN_W-1:0] h1_q [3];
  logic                   f_zero;

  assign f_zero = (n1_u[0] == '0) && (n1_u[1] == '0) && (n1_u[2] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= n1_v;
  end

  always_ff @(posedge clk_i) begin
    if (f_zero) f1_q <= '{'0, '0, ONE};
    else f1_q <= n1_u;
    for (int i = 0; i < 3; i++) begin
      e1_q[i] <= n1_pay[P1W-1-i*IN_W -: IN_W];
      h1_q[i] <= n1_pay[P1W-1-(3+i)*IN_W -: IN_W];
    end
  end

  // T2: products for hint . f and the world axis rejections
  logic                   v2_q;
  logic signed [HPW-1:0]  ph2_q [3];
  logic signed [FPW-1:0]  py2_q [3];
  logic signed [FPW-1:0]  pz2_q [3];
  logic signed [UW-1:0]   f2_q [3];
  logic signed [IN_W-1:0] e2_q [3];
  logic signed [IN_W-1:0] h2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ph2_q[i] <= h1_q[i] * f1_q[i];
      py2_q[i] <= f1_q[1] * f1_q[i];
      pz2_q[i] <= f1_q[2] * f1_q[i];
    end
    f2_q <= f1_q;
    e2_q <= e1_q;
    h2_q <= h1_q;
  end

  // T3: dot, world axis parts
  logic signed [HSW-1:0]  dsum;
  logic signed [HSW-1:0]  drnd;
  logic signed [FPW-1:0]  yr [3];
  logic signed [FPW-1:0]  zr [3];
  logic                   v3_q;
  logic signed [DW-1:0]   dot3_q;
  logic signed [UW:0]     cy3_q [3];
  logic signed [UW:0]     cz3_q [3];
  logic signed [UW-1:0]   f3_q [3];
  logic signed [IN_W-1:0] e3_q [3];
  logic signed [IN_W-1:0] h3_q [3];

  always_comb begin
    dsum = HSW'(ph2_q[0]) + HSW'(ph2_q[1]) + HSW'(ph2_q[2]);
    drnd = (dsum + HALF_H) >>> FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      yr[i] = (py2_q[i] + HALF_F) >>> FRAC_BITS;
      zr[i] = (pz2_q[i] + HALF_F) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    dot3_q <= drnd[DW-1:0];
    for (int i = 0; i < 3; i++) begin
      cy3_q[i] <= ((i == 1) ? (UW+1)'(ONE) : '0) - yr[i][UW:0];
      cz3_q[i] <= ((i == 2) ? (UW+1)'(ONE) : '0) - zr[i][UW:0];
    end
    f3_q <= f2_q;
    e3_q <= e2_q;
    h3_q <= h2_q;
  end

  // T4: dot * f
  logic                   v4_q;
  logic signed [PDW-1:0]  pd4_q [3];
  logic signed [UW:0]     cy4_q [3];
  logic signed [UW:0]     cz4_q [3];
  logic signed [UW-1:0]   f4_q [3];
  logic signed [IN_W-1:0] e4_q [3];
  logic signed [IN_W-1:0] h4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) pd4_q[i] <= dot3_q * f3_q[i];
    cy4_q <= cy3_q;
    cz4_q <= cz3_q;
    f4_q  <= f3_q;
    e4_q  <= e3_q;
    h4_q  <= h3_q;
  end

  // T5: hint part
  logic signed [PDW-1:0]  pdr [3];
  logic                   v5_q;
  logic signed [CW-1:0]   ch5_q [3];
  logic signed [CW-1:0]   cy5_q [3];
  logic signed [CW-1:0]   cz5_q [3];
  logic signed [UW-1:0]   f5_q [3];
  logic signed [IN_W-1:0] e5_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) pdr[i] = (pd4_q[i] + HALF_D) >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ch5_q[i] <= CW'(h4_q[i]) - pdr[i][CW-1:0];
      cy5_q[i] <= CW'(cy4_q[i]);
      cz5_q[i] <= CW'(cz4_q[i]);
    end
    f5_q <= f4_q;
    e5_q <= e4_q;
  end

  // T6: length test, magnitudes against threshold
  logic [CW-1:0]          hm [3];
  logic [CW-1:0]          ym [3];
  logic                   v6_q;
  logic                   hs6_q;
  logic                   ys6_q;
  logic [THR_W-1:0]       hl6_q [3];
  logic [THR_W-1:0]       yl6_q [3];
  logic signed [CW-1:0]   ch6_q [3];
  logic signed [CW-1:0]   cy6_q [3];
  logic signed [CW-1:0]   cz6_q [3];
  logic signed [UW-1:0]   f6_q [3];
  logic signed [IN_W-1:0] e6_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hm[i] = ch5_q[i][CW-1] ? CW'(-ch5_q[i]) : CW'(ch5_q[i]);
      ym[i] = cy5_q[i][CW-1] ? CW'(-cy5_q[i]) : CW'(cy5_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    hs6_q <= (hm[0] < CW'(thr_q)) && (hm[1] < CW'(thr_q)) && (hm[2] < CW'(thr_q));
    ys6_q <= (ym[0] < CW'(thr_q)) && (ym[1] < CW'(thr_q)) && (ym[2] < CW'(thr_q));
    for (int i = 0; i < 3; i++) begin
      hl6_q[i] <= hm[i][THR_W-1:0];
      yl6_q[i] <= ym[i][THR_W-1:0];
    end
    ch6_q <= ch5_q;
    cy6_q <= cy5_q;
    cz6_q <= cz5_q;
    f6_q  <= f5_q;
    e6_q  <= e5_q;
  end

  // T7: squares
  logic                   v7_q;
  logic                   hs7_q;
  logic                   ys7_q;
  logic [SQW-1:0]         hq7_q [3];
  logic [SQW-1:0]         yq7_q [3];
  logic signed [CW-1:0]   ch7_q [3];
  logic signed [CW-1:0]   cy7_q [3];
  logic signed [CW-1:0]   cz7_q [3];
  logic signed [UW-1:0]   f7_q [3];
  logic signed [IN_W-1:0] e7_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else v7_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      hq7_q[i] <= hl6_q[i] * hl6_q[i];
      yq7_q[i] <= yl6_q[i] * yl6_q[i];
    end
    hs7_q <= hs6_q;
    ys7_q <= ys6_q;
    ch7_q <= ch6_q;
    cy7_q <= cy6_q;
    cz7_q <= cz6_q;
    f7_q  <= f6_q;
    e7_q  <= e6_q;
  end

  // T8: choose the up part
  logic [SQW+1:0]         hsum;
  logic [SQW+1:0]         ysum;
  logic                   h_short;
  logic                   y_short;
  logic                   v8_q;
  logic signed [CW-1:0]   c8_q [3];
  logic signed [UW-1:0]   f8_q [3];
  logic signed [IN_W-1:0] e8_q [3];

  always_comb begin
    hsum    = (SQW+2)'(hq7_q[0]) + (SQW+2)'(hq7_q[1]) + (SQW+2)'(hq7_q[2]);
    ysum    = (SQW+2)'(yq7_q[0]) + (SQW+2)'(yq7_q[1]) + (SQW+2)'(yq7_q[2]);
    h_short = hs7_q && (hsum < (SQW+2)'(thr_sq_q));
    y_short = ys7_q && (ysum < (SQW+2)'(thr_sq_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else v8_q <= v7_q;
  end

  always_ff @(posedge clk_i) begin
    if (!h_short) c8_q <= ch7_q;
    else if (!y_short) c8_q <= cy7_q;
    else c8_q <= cz7_q;
    f8_q <= f7_q;
    e8_q <= e7_q;
  end

  // up normaliser
  logic                 n2_v;
  logic signed [UW-1:0] n2_u [3];
  logic [P2W-1:0]       n2_pay;

  lavm_norm #(
    .VW       (CW),
    .FRAC_BITS(FRAC_BITS),
    .PW       (P2W)
  ) u_norm_up (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v8_q),
    .vec_i  (c8_q),
    .pay_i  ({e8_q[0], e8_q[1], e8_q[2], f8_q[0], f8_q[1], f8_q[2]}),
    .valid_o(n2_v),
    .unit_o (n2_u),
    .pay_o  (n2_pay)
  );

  // T9: cross products
  logic                   v9_q;
  logic signed [FPW-1:0]  cp9_q [6];
  logic signed [UW-1:0]   u9_q [3];
  logic signed [UW-1:0]   f9_q [3];
  logic signed [IN_W-1:0] e9_q [3];
  logic signed [UW-1:0]   f_up [3];

  always_comb begin
    for (int i = 0; i < 3; i++) f_up[i] = n2_pay[P2W-1-3*IN_W-i*UW -: UW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else v9_q <= n2_v;
  end

  always_ff @(posedge clk_i) begin
    cp9_q[0] <= n2_u[1] * f_up[2];
    cp9_q[1] <= n2_u[2] * f_up[1];
    cp9_q[2] <= n2_u[2] * f_up[0];
    cp9_q[3] <= n2_u[0] * f_up[2];
    cp9_q[4] <= n2_u[0] * f_up[1];
    cp9_q[5] <= n2_u[1] * f_up[0];
    for (int i = 0; i < 3; i++) e9_q[i] <= n2_pay[P2W-1-i*IN_W -: IN_W];
    u9_q <= n2_u;
    f9_q <= f_up;
  end

  // T10: right axis
  logic signed [XPW-1:0]  xr [3];
  logic                   v10_q;
  logic signed [UW-1:0]   r10_q [3];
  logic signed [UW-1:0]   u10_q [3];
  logic signed [UW-1:0]   f10_q [3];
  logic signed [IN_W-1:0] e10_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      xr[i] = (XPW'(cp9_q[2*i]) - XPW'(cp9_q[2*i+1]) + HALF_X) >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v10_q <= 1'b0;
    else v10_q <= v9_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (xr[i] > ONE_X) r10_q[i] <= ONE;
      else if (xr[i] < -ONE_X) r10_q[i] <= -ONE;
      else r10_q[i] <= xr[i][UW-1:0];
    end
    u10_q <= u9_q;
    f10_q <= f9_q;
    e10_q <= e9_q;
  end

  // T11: eye against each axis
  logic                  v11_q;
  logic signed [EPW-1:0] pr11_q [3];
  logic signed [EPW-1:0] pu11_q [3];
  logic signed [EPW-1:0] pf11_q [3];
  logic signed [UW-1:0]  r11_q [3];
  logic signed [UW-1:0]  u11_q [3];
  logic signed [UW-1:0]  f11_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v11_q <= 1'b0;
    else v11_q <= v10_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pr11_q[i] <= e10_q[i] * r10_q[i];
      pu11_q[i] <= e10_q[i] * u10_q[i];
      pf11_q[i] <= e10_q[i] * f10_q[i];
    end
    r11_q <= r10_q;
    u11_q <= u10_q;
    f11_q <= f10_q;
  end

  // T12: translation, saturate
  logic signed [ESW-1:0]  tsum [3];
  logic signed [ESW-1:0]  trnd [3];
  logic signed [NSW-1:0]  tneg [3];
  logic                   v12_q;
  logic signed [UW-1:0]   r12_q [3];
  logic signed [UW-1:0]   u12_q [3];
  logic signed [UW-1:0]   f12_q [3];
  logic signed [IN_W-1:0] s12_q [3];

  always_comb begin
    tsum[0] = ESW'(pr11_q[0]) + ESW'(pr11_q[1]) + ESW'(pr11_q[2]);
    tsum[1] = ESW'(pu11_q[0]) + ESW'(pu11_q[1]) + ESW'(pu11_q[2]);
    tsum[2] = ESW'(pf11_q[0]) + ESW'(pf11_q[1]) + ESW'(pf11_q[2]);
    for (int i = 0; i < 3; i++) begin
      trnd[i] = (tsum[i] + HALF_E) >>> FRAC_BITS;
      tneg[i] = -NSW'(trnd[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v12_q <= 1'b0;
    else v12_q <= v11_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (tneg[i] > S_MAX) s12_q[i] <= S_MAX[IN_W-1:0];
      else if (tneg[i] < S_MIN) s12_q[i] <= S_MIN[IN_W-1:0];
      else s12_q[i] <= tneg[i][IN_W-1:0];
    end
    r12_q <= r11_q;
    u12_q <= u11_q;
    f12_q <= f11_q;
  end

  assign done_o      = v12_q;
  assign right_x_o   = OUT_W'(r12_q[0]);
  assign right_y_o   = OUT_W'(r12_q[1]);
  assign right_z_o   = OUT_W'(r12_q[2]);
  assign upward_x_o  = OUT_W'(u12_q[0]);
  assign upward_y_o  = OUT_W'(u12_q[1]);
  assign upward_z_o  = OUT_W'(u12_q[2]);
  assign forward_x_o = OUT_W'(f12_q[0]);
  assign forward_y_o = OUT_W'(f12_q[1]);
  assign forward_z_o = OUT_W'(f12_q[2]);
  assign shift_x_o   = s12_q[0];
  assign shift_y_o   = s12_q[1];
  assign shift_z_o   = s12_q[2];

endmodule

// ----- tb/sv/tb_look_at_view_matrix.sv -----
`timescale 1ns / 1ps
module tb_look_at_view_matrix;
  import lavm_pkg::*;

  localparam int  FB       = 16;
  localparam longint ONE   = 64'sd1 <<< FB;
  localparam int  DRAIN    = 140;
  localparam int  WD_LIMIT = 20000;
  localparam int  N_PHASE  = 5;
  localparam int  PER_PH   = 360;

  typedef logic [8:0][31:0]  cam_t;   // eye xyz, target xyz, up hint xyz
  typedef logic [11:0][31:0] basis_t; // right, upward, forward, shift
  typedef struct {
    logic [THR_W-1:0] thr;
    cam_t             cam;
    bit               typed;
    basis_t           res;
  } row_t;

  logic clk_i, rst_ni, start_i, busy_o, cfg_valid_i, cfg_ready_o, done_o;
  logic [THR_W-1:0] cfg_data_i;
  logic signed [IN_W-1:0] eye_x_i, eye_y_i, eye_z_i, target_x_i, target_y_i, target_z_i;
  logic signed [IN_W-1:0] up_hint_x_i, up_hint_y_i, up_hint_z_i;
  logic signed [OUT_W-1:0] right_x_o, right_y_o, right_z_o, upward_x_o, upward_y_o;
  logic signed [OUT_W-1:0] upward_z_o, forward_x_o, forward_y_o, forward_z_o;
  logic signed [IN_W-1:0] shift_x_o, shift_y_o, shift_z_o;

  look_at_view_matrix #(.FRAC_BITS(FB)) dut (.*);

  basis_t      basis_q[$];
  row_t        rows[$];
  longint unsigned thr_cur;
  int          errors, n_sent, n_seen, idle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint rnd_frac(longint x);
    return (x + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint clampl(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint unsigned magl(longint x);
    return x < 0 ? longint'(64'd0 - x) : x;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3], big, sum, len, q;
    big = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = magl(v[i]);
      if (m[i] > big) big = m[i];
    end
    if (big == 0) begin
      u = '{0, 0, 0};
      return 1'b0;
    end
    while (big >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      big = big >> 1;
    end
    while (big < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      big = big << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + len / 2) / len;
      if (q > ONE) q = ONE;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic bit too_short(input longint v[3], input longint unsigned thr);
    longint unsigned sum, m;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = magl(v[i]);
      if (m >= thr) return 1'b0;
      sum = sum + m * m;
    end
    return sum < thr * thr;
  endfunction

  function automatic void orth_part(input longint a[3], input longint dot,
                                    input longint f[3], output longint c[3]);
    for (int i = 0; i < 3; i++) c[i] = a[i] - rnd_frac(dot * f[i]);
  endfunction

  function automatic basis_t predict_basis(cam_t cam, longint unsigned thr);
    longint e[3], d[3], h[3], f[3], c[3], u[3], r[3], s[3], dot;
    longint ay[3], az[3];
    basis_t res;
    ay = '{0, ONE, 0};
    az = '{0, 0, ONE};
    for (int i = 0; i < 3; i++) begin
      e[i] = longint'($signed(cam[i]));
      d[i] = longint'($signed(cam[3 + i])) - e[i];
      h[i] = longint'($signed(cam[6 + i]));
    end
    if (!unit_vec(d, f)) f = '{0, 0, ONE};
    dot = rnd_frac(h[0] * f[0] + h[1] * f[1] + h[2] * f[2]);
    orth_part(h, dot, f, c);
    if (too_short(c, thr)) begin
      orth_part(ay, f[1], f, c);
      if (too_short(c, thr)) orth_part(az, f[2], f, c);
    end
    void'(unit_vec(c, u));
    r[0] = clampl(rnd_frac(u[1] * f[2] - u[2] * f[1]), -ONE, ONE);
    r[1] = clampl(rnd_frac(u[2] * f[0] - u[0] * f[2]), -ONE, ONE);
    r[2] = clampl(rnd_frac(u[0] * f[1] - u[1] * f[0]), -ONE, ONE);
    s[0] = -rnd_frac(e[0] * r[0] + e[1] * r[1] + e[2] * r[2]);
    s[1] = -rnd_frac(e[0] * u[0] + e[1] * u[1] + e[2] * u[2]);
    s[2] = -rnd_frac(e[0] * f[0] + e[1] * f[1] + e[2] * f[2]);
    for (int i = 0; i < 3; i++) begin
      res[i]     = r[i][31:0];
      res[3 + i] = u[i][31:0];
      res[6 + i] = f[i][31:0];
      res[9 + i] = 32'(clampl(s[i], -64'sd2147483648, 64'sd2147483647));
    end
    return res;
  endfunction

  // directed rows
  function automatic cam_t mk_cam(int ex, int ey, int ez, int tx, int ty, int tz,
                                  int ux, int uy, int uz);
    cam_t c;
    c = {uz, uy, ux, tz, ty, tx, ez, ey, ez};
    c[0] = ex;
    return c;
  endfunction

  function automatic basis_t mk_basis(int rx, int ry, int rz, int ux, int uy, int uz,
                                      int fx, int fy, int fz);
    return {32'd0, 32'd0, 32'd0, fz, fy, fx, uz, uy, ux, rz, ry, rx};
  endfunction

  task automatic add_row(logic [THR_W-1:0] thr, cam_t cam, bit typed, basis_t res);
    row_t rw;
    rw.thr = thr;
    rw.cam = cam;
    rw.typed = typed;
    rw.res = res;
    rows.push_back(rw);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (basis_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_thr(logic [THR_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_cur = v;
  endtask

  task automatic send(cam_t cam, bit typed, basis_t res);
    {up_hint_z_i, up_hint_y_i, up_hint_x_i, target_z_i, target_y_i, target_x_i,
     eye_z_i, eye_y_i, eye_x_i} <= cam;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    basis_q.push_back(typed ? res : predict_basis(cam, thr_cur));
    n_sent++;
  endtask

  function automatic int small_val(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic cam_t rand_cam();
    cam_t c;
    int k, d0, d1, d2;
    for (int i = 0; i < 9; i++) c[i] = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4, 5: for (int i = 0; i < 9; i++) c[i] = small_val(1 << 20);
      6: begin
        for (int i = 0; i < 3; i++) c[i] = small_val(1 << 20);
        d0 = small_val(1 << 16);
        d1 = small_val(1 << 16);
        d2 = small_val(1 << 16);
        k = small_val(4);
        c[3] = c[0] + d0; c[4] = c[1] + d1; c[5] = c[2] + d2;
        c[6] = d0 * k; c[7] = d1 * k; c[8] = d2 * k;
      end
      7: begin
        for (int i = 0; i < 3; i++) c[i] = small_val(1 << 20);
        c[3] = c[0] + small_val($urandom_range(0, 3));
        c[4] = c[1] + small_val(1 << 20);
        c[5] = c[2] + small_val($urandom_range(0, 3));
        c[6] = small_val(2); c[7] = small_val(1 << 18); c[8] = small_val(2);
      end
      8: begin
        c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
        if ($urandom_range(0, 1)) for (int i = 6; i < 9; i++) c[i] = small_val(3);
      end
      default: for (int i = 6; i < 9; i++) c[i] = small_val(3);
    endcase
    return c;
  endfunction

  always @(posedge clk_i) begin
    basis_t want, got;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WD_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cnt);
        $display("FAILED: results differ");
        $finish;
      end
      if (done_o) begin
        n_seen++;
        got = {shift_z_o, shift_y_o, shift_x_o,
               32'(forward_z_o), 32'(forward_y_o), 32'(forward_x_o),
               32'(upward_z_o), 32'(upward_y_o), 32'(upward_x_o),
               32'(right_z_o), 32'(right_y_o), 32'(right_x_o)};
        if (basis_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result, got %h", $time, got);
        end else begin
          want = basis_q.pop_front();
          for (int i = 0; i < 12; i++) if (want[i] !== got[i]) begin
            errors++;
            $display("%0t field %0d: expected %0d actual %0d", $time, i,
                     $signed(want[i]), $signed(got[i]));
          end
        end
      end
    end
  end

  initial begin
    int gap_pct[N_PHASE];
    logic [THR_W-1:0] ph_thr[N_PHASE];
    basis_t zb;
    zb = '0;
    gap_pct = '{0, 64, 0, 10, 64};
    ph_thr  = '{17'd1, 17'd0, 17'd65536, 17'd0, 17'd300};
    ph_thr[3] = $urandom_range(2, 65535);
    errors = 0; n_sent = 0; n_seen = 0; idle_cnt = 0;
    thr_cur = THR_RST;
    rst_ni = 1'b0; start_i = 1'b0; cfg_valid_i = 1'b0; cfg_data_i = '0;
    {eye_x_i, eye_y_i, eye_z_i, target_x_i, target_y_i, target_z_i} = '0;
    {up_hint_x_i, up_hint_y_i, up_hint_z_i} = '0;

    // eye on target, no hint: forward +Z, up from world Y
    add_row(17'd1, mk_cam(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_basis(65536, 0, 0, 0, 65536, 0, 0, 0, 65536));
    add_row(17'd1, mk_cam(0, 0, 0, 0, 0, 65536, 0, 65536, 0), 1'b1,
            mk_basis(65536, 0, 0, 0, 65536, 0, 0, 0, 65536));
    add_row(17'd1, mk_cam(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h80000000, 32'h7fffffff), 1'b0, zb);
    add_row(17'd1, mk_cam(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h80000000, 32'h7fffffff, 32'h80000000), 1'b0, zb);
    add_row(17'd1, mk_cam(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0,
                          32'h80000000, 32'hffffffff, 32'hffffffff, 1), 1'b0, zb);
    add_row(17'd1, mk_cam(65536, 131072, -65536, 65536, 655360, -65536,
                          0, 65536, 0), 1'b0, zb);
    add_row(17'd1, mk_cam(12345, -999, 4, 12345, -999, 4, 1, 2, 3), 1'b0, zb);
    add_row(17'd1, mk_cam(1, 2, 3, 4, 5, 6, 3, 3, 3), 1'b0, zb);
    // threshold zero, hint zero: chosen part exactly zero
    add_row(17'd0, mk_cam(0, 0, 0, 0, 0, 65536, 0, 0, 0), 1'b1,
            mk_basis(0, 0, 0, 0, 0, 0, 0, 0, 65536));
    add_row(17'd0, mk_cam(5, 6, 7, 5, 9, 7, 0, 1, 0), 1'b0, zb);
    add_row(17'd0, mk_cam(-70000, 3, 3, 900000, 3, 3, 1, 0, 0), 1'b0, zb);
    // widest threshold: both fallbacks short
    add_row(17'd65536, mk_cam(0, 0, 0, 65536, 65536, 65536, 0, 65536, 0), 1'b0, zb);
    add_row(17'd65536, mk_cam(100, -200, 300, -4000, 5000, 60000,
                              32'h7fffffff, 0, 0), 1'b0, zb);
    add_row(17'd65536, mk_cam(0, 0, 0, 0, 65536, 0, 0, 65536, 0), 1'b0, zb);
    add_row(17'd65536, mk_cam(0, 0, 0, 1, 65536, 1, 0, 0, 0), 1'b0, zb);
    add_row(17'd40000, mk_cam(0, 0, 0, 0, 0, 0, 30000, 0, 0), 1'b0, zb);
    add_row(17'd40000, mk_cam(7, 7, 7, 8, 7, 7, 0, 50000, 0), 1'b0, zb);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].thr != thr_cur) begin
        drain();
        write_thr(rows[i].thr);
      end
      send(rows[i].cam, rows[i].typed, rows[i].res);
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      drain();
      write_thr(ph_thr[ph]);
      for (int n = 0; n < PER_PH; n++) begin
        send(rand_cam(), 1'b0, zb);
        if (ph == 1 && n == PER_PH / 2) begin
          start_i <= 1'b0;
          while (basis_q.size() != 0) @(posedge clk_i);
        end else if ($urandom_range(0, 99) < gap_pct[ph] && n % 100 < 80) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
    end

    drain();
    $display("covered %0d camera sets, %0d results, thresholds 0/1/300/random/65536",
             n_sent, n_seen);
    $display("degenerate hints, eye on target and full-range coordinates included");
    if (errors == 0 && basis_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lavm_pkg.sv
sv/lavm_norm.sv
sv/look_at_view_matrix.sv
tb/sv/tb_look_at_view_matrix.sv
